// ----- design/assert_macros.svh -----
// Assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check an implication in the next cycle outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- design/pfio_pkg.sv -----
// ----------------------------------------------------------------------------
// pfio_pkg
// Types and codes shared by the fade gain block.
// ----------------------------------------------------------------------------
`default_nettype none
package pfio_pkg;
	localparam logic [1:0] FMT_U8  = 2'd0;
	localparam logic [1:0] FMT_S16 = 2'd1;
	localparam logic [1:0] FMT_S24 = 2'd2;
	localparam logic [1:0] FMT_S32 = 2'd3;
	localparam logic [1:0] CURVE_LIN    = 2'd0;
	localparam logic [1:0] CURVE_SMOOTH = 2'd1;
	localparam logic [1:0] CURVE_LOG    = 2'd2;
	localparam logic [2:0] REG_FORMAT   = 3'd0;
	localparam logic [2:0] REG_CHANNELS = 3'd1;
	localparam logic [2:0] REG_CLIP     = 3'd2;
	localparam logic [2:0] REG_FADE_IN  = 3'd3;
	localparam logic [2:0] REG_FADE_OUT = 3'd4;
	localparam logic [2:0] REG_CURVE    = 3'd5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	typedef logic signed [31:0] sample_t;
endpackage
`default_nettype wire

// ----- design/pfio_if.sv -----
// ----------------------------------------------------------------------------
// pfio channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface pfio_in_if import pfio_pkg::*; ();
	logic valid;
	logic ready;
	sample_t sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface pfio_out_if import pfio_pkg::*; ();
	logic valid;
	logic ready;
	sample_t sample_out;
	logic clip_end;
	modport source (output valid, output sample_out, output clip_end, input ready);
	modport sink (input valid, input sample_out, input clip_end, output ready);
endinterface

interface pfio_cfg_if import pfio_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/pcm_fade_in_out_gain.sv -----
// Steps: a clip/channel division, then a fade-in pass and a fade-out pass; an active pass
// adds a fade division and a scaling step, with square and cube steps first for smoothstep.
// Divisions share one divider; multiply steps share the 32x(GAIN_FRAC_BITS+2) multiplier.
// Input: a sample is taken only once the last result is in the output register; the next
// sample is taken while a result waits there, and a second waiting result holds the block.
// Reset: arst_n clears registers to their reset values and all counters.
// ----------------------------------------------------------------------------
// pcm_fade_in_out_gain
// Fade-in / fade-out gain envelope over one interleaved PCM clip.
// ----------------------------------------------------------------------------
`default_nettype none
module pcm_fade_in_out_gain import pfio_pkg::*; #(
	parameter int MAX_CHANNELS = 8,
	parameter int GAIN_FRAC_BITS = 16,
	parameter int FRAME_COUNT_BITS = 24
) (
	input wire clk,
	input wire arst_n,
	pfio_in_if.sink in_ch,
	pfio_out_if.source out_ch,
	pfio_cfg_if.sink cfg
);
	localparam int G = GAIN_FRAC_BITS;
	localparam int NW = 32;
	localparam int DW = NW + G + 2;
	localparam int MAW = 32;
	localparam int MBW = G + 2;
	localparam int MPW = MAW + MBW;
	localparam int CW = $clog2(DW + 1);
	localparam logic [FRAME_COUNT_BITS-1:0] FMAX = '1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLAMP = 4'd1;
	localparam logic [3:0] ST_DIVCL = 4'd2;
	localparam logic [3:0] ST_PREP = 4'd3;
	localparam logic [3:0] ST_DIV = 4'd4;
	localparam logic [3:0] ST_SQ = 4'd5;
	localparam logic [3:0] ST_CUB = 4'd6;
	localparam logic [3:0] ST_SCALE = 4'd7;
	localparam logic [3:0] ST_NEXT = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [1:0] fmt_q, curve_q;
	logic [3:0] chan_q;
	logic [30:0] clip_q;
	logic [23:0] fin_q, fout_q;
	logic [30:0] pos_q;
	logic [4:0] iph_q, oph_q;
	logic [FRAME_COUNT_BITS-1:0] ifr_q, ofr_q;
	logic [3:0] st_q;
	logic pass_q;
	logic [30:0] cfr_q;
	logic signed [33:0] v_q;
	logic [DW-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [MBW-1:0] g_q;
	logic [31:0] res_q;
	logic end_q, ovalid_q;

	logic [5:0] nc;
	logic [30:0] fin_c, fout_c, f_cur, span, k, d, n;
	logic in_act, out_act, act;
	logic [DW:0] rem_sh;
	logic qbit;
	logic [DW-1:0] quo_nx;
	logic [MAW-1:0] ma;
	logic [MBW-1:0] mb;
	logic [MPW-1:0] mp;
	logic [33:0] vmag;
	logic signed [33:0] vnext;
	logic last;
	logic emit;

	always_comb begin
		nc = (chan_q == 4'd0) ? 6'd1 : {2'b0, chan_q};
		if (32'(nc) > 32'(MAX_CHANNELS)) nc = 6'(MAX_CHANNELS);
	end

	assign fin_c = ({7'b0, fin_q} > cfr_q) ? cfr_q : {7'b0, fin_q};
	assign fout_c = ({7'b0, fout_q} > cfr_q) ? cfr_q : {7'b0, fout_q};
	assign f_cur = pass_q ? fout_c : fin_c;
	always_comb begin
		if (pass_q) span = ({7'b0, fout_q} > cfr_q) ? clip_q : 31'(fout_c * nc);
		else span = ({7'b0, fin_q} > cfr_q) ? clip_q : 31'(fin_c * nc);
		if (pass_q) in_act = 1'b0;
		else in_act = (fin_c > 31'd1) && (pos_q < span);
		out_act = pass_q && (fout_c > 31'd1) && ({1'b0, pos_q} >= 32'(clip_q) - 32'(span))
			&& (pos_q < clip_q);
		act = in_act || out_act;
		d = f_cur - 31'd1;
		k = pass_q ? ((31'(ofr_q) < d) ? 31'(ofr_q) : d)
			: ((31'(ifr_q) < d) ? 31'(ifr_q) : d);
		n = pass_q ? d - k : k;
	end

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign qbit = rem_sh >= {1'b0, den_q};
	assign quo_nx = {quo_q[DW-2:0], qbit};
	assign mp = MPW'(ma) * MPW'(mb);
	assign vmag = v_q[33] ? 34'(-v_q) : 34'(v_q);
	assign last = (clip_q != 31'd0) && (pos_q == clip_q - 31'd1);
	assign emit = (st_q == ST_OUT) && (!ovalid_q || out_ch.ready);

	always_comb begin
		ma = MAW'(quo_q);
		mb = MBW'(quo_q);
		unique case (st_q)
			ST_CUB: begin
				ma = MAW'(g_q);
				mb = (MBW'(3) << G) - MBW'({quo_q, 1'b0});
			end
			ST_SCALE: begin
				ma = MAW'(vmag);
				mb = g_q;
			end
			default: begin
				ma = MAW'(quo_q);
				mb = MBW'(quo_q);
			end
		endcase
		vnext = v_q[33] ? -34'(mp >> G) : 34'(mp >> G);
	end

	assign in_ch.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = ovalid_q;
	assign out_ch.sample_out = res_q;
	assign out_ch.clip_end = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_S16;
			chan_q <= 4'd2;
			clip_q <= '0;
			fin_q <= '0;
			fout_q <= '0;
			curve_q <= CURVE_LIN;
			pos_q <= '0;
			iph_q <= '0;
			oph_q <= '0;
			ifr_q <= '0;
			ofr_q <= '0;
			st_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			pass_q <= 1'b0;
			end_q <= 1'b0;
			cnt_q <= '0;
			cfr_q <= '0;
			v_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			g_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_FORMAT: fmt_q <= cfg.data[1:0];
					REG_CHANNELS: chan_q <= cfg.data[3:0];
					REG_CLIP: clip_q <= cfg.data[30:0];
					REG_FADE_IN: fin_q <= cfg.data[23:0];
					REG_FADE_OUT: fout_q <= cfg.data[23:0];
					REG_CURVE: curve_q <= cfg.data[1:0];
					default: ;
				endcase
			end
			if (emit) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_ch.valid) begin
					unique case (fmt_q)
						FMT_U8: v_q <= 34'($signed({1'b0, in_ch.sample_in[7:0]})) - 34'sd128;
						FMT_S16: v_q <= 34'(signed'(in_ch.sample_in[15:0]));
						FMT_S24: v_q <= 34'(signed'(in_ch.sample_in[23:0]));
						default: v_q <= 34'(in_ch.sample_in);
					endcase
					rem_q <= '0;
					quo_q <= DW'(clip_q) << (DW - 31);
					den_q <= DW'(nc);
					cnt_q <= CW'(31);
					st_q <= ST_DIVCL;
				end
				ST_DIVCL: begin
					if (qbit) rem_q <= DW'(rem_sh - {1'b0, den_q});
					else rem_q <= DW'(rem_sh);
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) st_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					cfr_q <= quo_q[30:0];
					pass_q <= 1'b0;
					st_q <= ST_PREP;
				end
				ST_PREP: begin
					if (act) begin
						rem_q <= '0;
						quo_q <= DW'({n, {G{1'b0}}}) << (DW - 31 - G);
						den_q <= (curve_q == CURVE_LOG) ? DW'({d, 1'b0} - {1'b0, n})
							: DW'(d);
						cnt_q <= CW'(31 + G);
						st_q <= ST_DIV;
					end else st_q <= ST_NEXT;
				end
				ST_DIV: begin
					if (qbit) rem_q <= DW'(rem_sh - {1'b0, den_q});
					else rem_q <= DW'(rem_sh);
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						if (curve_q == CURVE_SMOOTH) st_q <= ST_SQ;
						else begin
							g_q <= MBW'(quo_nx);
							st_q <= ST_SCALE;
						end
					end
				end
				ST_SQ: begin
					g_q <= MBW'(mp >> G);
					st_q <= ST_CUB;
				end
				ST_CUB: begin
					g_q <= MBW'(mp >> G);
					st_q <= ST_SCALE;
				end
				ST_SCALE: begin
					v_q <= vnext;
					if (pass_q) begin
						if (oph_q + 5'd1 >= 5'(nc)) begin
							oph_q <= '0;
							if (ofr_q < FMAX) ofr_q <= ofr_q + 1'b1;
						end else oph_q <= oph_q + 5'd1;
					end else begin
						if (iph_q + 5'd1 >= 5'(nc)) begin
							iph_q <= '0;
							if (ifr_q < FMAX) ifr_q <= ifr_q + 1'b1;
						end else iph_q <= iph_q + 5'd1;
					end
					st_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						st_q <= ST_PREP;
					end else st_q <= ST_OUT;
				end
				ST_OUT: if (emit) begin
					res_q <= (fmt_q == FMT_U8) ? {24'b0, 8'(v_q + 34'sd128)} : v_q[31:0];
					end_q <= last;
					if (last) begin
						pos_q <= '0;
						iph_q <= '0;
						oph_q <= '0;
						ifr_q <= '0;
						ofr_q <= '0;
					end else pos_q <= pos_q + 31'd1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/pfio_checker.sv -----
// ----------------------------------------------------------------------------
// pfio_checker
// Port-level checks on the fade gain block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pfio_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire [31:0] sample_out,
	input wire clip_end
);
	`CHK_IMPL(a_out_known, clk, arst_n, out_valid, !$isunknown({sample_out, clip_end}), "unknown result")
	`CHK_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(clip_end), "result changed while stalled")
	`CHK_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready, "ready right after transfer")
endmodule

bind pcm_fade_in_out_gain pfio_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.sample_out(out_ch.sample_out), .clip_end(out_ch.clip_end)
);
`default_nettype wire
